FILE: rtl/hold_resampler_with_fade_in_assert.svh
// Assertion macros used by the frame generator of the resampler RTL.
`ifndef HOLD_RESAMPLER_WITH_FADE_IN_ASSERT_SVH
`define HOLD_RESAMPLER_WITH_FADE_IN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRFI_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("hrfi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRFI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("hrfi assertion failed");

`endif

FILE: rtl/hrfi_pkg.sv
// Types and constants shared by the hold resampler modules.
`default_nettype none

package hrfi_pkg;

  localparam int MAX_OUT_FRAMES = 262144;
  localparam int CNT_W          = $clog2(MAX_OUT_FRAMES + 1);

  localparam int SAMPLE_W   = 16;
  localparam int QUO_W      = 10;
  localparam int PHASE_W    = 10;
  localparam int STEP_W     = 16;
  localparam int ACC_W      = STEP_W + 1;
  localparam int ADV_W      = ACC_W - PHASE_W;
  localparam int FRAMES_W   = 6;
  localparam int SKIP_W     = 6;
  localparam int GAIN_W     = 7;
  localparam int GAIN_FULL  = 64;
  localparam int MIN_STEP   = 16;
  localparam int DIV_SHIFT  = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INC    = 2'd2;

  localparam logic [STEP_W-1:0]   RST_STEP        = 16'd780;
  localparam logic [FRAMES_W-1:0] RST_FADE_FRAMES = 6'd44;
  localparam logic [STEP_W-1:0]   RST_RAMP_INC    = 16'd1489;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ch_a;
    logic signed [SAMPLE_W-1:0] ch_b;
    logic signed [QUO_W-1:0]    quo_a;
    logic signed [QUO_W-1:0]    quo_b;
    logic                       first;
    logic                       last;
    logic                       fade;
  } item_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [FRAMES_W-1:0] fade_frames;
    logic [STEP_W-1:0]   ramp_inc;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/hold_resampler_with_fade_in.sv
// Top level of the sample-and-hold resampler with fade-in: configuration registers and the stages.
//
// Input stream: tdata carries one packed stereo word (first channel in bits 31:16, second in
// bits 15:0), tuser bit 0 starts a block, tuser bit 1 requests a fade-in for that block and
// tlast marks the final word of the block.
// Output stream: one stereo frame per transfer; tdata holds the first channel in bits 15:0 and
// the second in bits 31:16, tuser bit 0 ends the run caused by one input word, tuser bit 1 marks
// the frame that reaches the frame limit, and tlast marks the last frame of the block.
// The first frame of a word passes the input register, the queue and the output register.
// Throughput: the frame generator produces one frame per cycle while the output is not stalled,
// and a skipped word is dropped from the queue without a frame; the input register and a two-entry
// queue let words be accepted while earlier frames are still being produced.
// Configuration is to be written through the register port only while the block is idle; the
// block itself does not enforce this. Reset clears all accumulators and counters and loads the
// default step and fade settings. When the receiver stalls the output frame holds, the
// generator waits, the queue fills and the input stream is then held off.
`default_nettype none

module hold_resampler_with_fade_in
  import hrfi_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [31:0]           s_axis_tdata_i,  // sample_word
  input  wire logic [1:0]            s_axis_tuser_i,  // first_of_block, fade_in
  input  wire logic                  s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [31:0]                m_axis_tdata_o,  // first_channel, second_channel
  output logic [1:0]                 m_axis_tuser_o,  // run_end, truncated
  output logic                       m_axis_tlast_o
);

  cfg_t    cfg_q, cfg_d;
  logic    push_valid, push_ready, pop;
  item_t   push_item, head_item;
  q_ctrl_t head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STEP:        cfg_d.step        = cfg_data_i;
        REG_FADE_FRAMES: cfg_d.fade_frames = cfg_data_i[FRAMES_W-1:0];
        REG_RAMP_INC:    cfg_d.ramp_inc    = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step        <= RST_STEP;
      cfg_q.fade_frames <= RST_FADE_FRAMES;
      cfg_q.ramp_inc    <= RST_RAMP_INC;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hrfi_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  hrfi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .head_o       (head),
    .pop_i        (pop),
    .head_item_o  (head_item)
  );

  hrfi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .head_item_i     (head_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

FILE: rtl/hrfi_front.sv
// Input stage: registers each word and splits and pre-divides its channels.
`default_nettype none

module hrfi_front
  import hrfi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tlast_i,
  output logic             push_valid_o,
  input  wire logic        push_ready_i,
  output item_t            push_item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  item_t item_d;
  logic  accept;
  logic signed [SAMPLE_W-1:0] ch_a, ch_b, bias_a, bias_b;

  // Division by 64 truncating toward zero: bias negative values first.
  always_comb begin
    ch_a   = s_axis_tdata_i[31:16];
    ch_b   = s_axis_tdata_i[15:0];
    bias_a = ch_a + (ch_a[SAMPLE_W-1] ? SAMPLE_W'(63) : '0);
    bias_b = ch_b + (ch_b[SAMPLE_W-1] ? SAMPLE_W'(63) : '0);
    item_d.ch_a  = ch_a;
    item_d.ch_b  = ch_b;
    item_d.quo_a = bias_a[SAMPLE_W-1:DIV_SHIFT];
    item_d.quo_b = bias_b[SAMPLE_W-1:DIV_SHIFT];
    item_d.first = s_axis_tuser_i[0];
    item_d.fade  = s_axis_tuser_i[1];
    item_d.last  = s_axis_tlast_i;
  end

  assign s_axis_tready_o = !valid_q || push_ready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

endmodule

`default_nettype wire

FILE: rtl/hrfi_fifo.sv
// Short queue of classified words between the input stage and the frame generator.
`default_nettype none

module hrfi_fifo
  import hrfi_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output q_ctrl_t    head_o,
  input  wire logic  pop_i,
  output item_t      head_item_o
);

  item_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign head_o.valid = count_q != '0;
  assign head_o.pop   = pop;
  assign head_item_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: rtl/hrfi_back.sv
// Frame generator: phase accumulator, skip counter, fade ramp, frame limit and output register.
`default_nettype none
`include "hold_resampler_with_fade_in_assert.svh"

module hrfi_back
  import hrfi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire q_ctrl_t     head_i,
  input  wire item_t       head_item_i,
  output logic             pop_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [SKIP_W-1:0]   skip_q, skip_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [FRAMES_W-1:0] fidx_q, fidx_d;
  logic [PHASE_W-1:0]  facc_q, facc_d;
  logic [GAIN_W-1:0]   gain_q, gain_d;
  logic                fading_q, fading_d;
  logic                limit_q, limit_d;
  logic                busy_q, busy_d;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_a_q, out_b_q, out_a_d, out_b_d;
  logic                out_run_end_q, out_block_end_q, out_trunc_q;

  logic [PHASE_W-1:0]  eff_phase, eff_facc;
  logic [SKIP_W-1:0]   eff_skip;
  logic [CNT_W-1:0]    eff_cnt, cnt_new;
  logic [FRAMES_W-1:0] eff_fidx;
  logic [FRAMES_W:0]   fidx_next;
  logic [GAIN_W-1:0]   eff_gain, gain_new;
  logic [GAIN_W:0]     gain_sum;
  logic                eff_fading, eff_limit, start;
  logic                drop, slot_free, emit, fade_now, hit, run_done;
  logic [ACC_W-1:0]    facc_sum, acc_sum;
  logic [STEP_W-1:0]   step_eff;
  logic [ADV_W-1:0]    adv;
  logic signed [GAIN_W:0]             gain_s;
  logic signed [QUO_W+GAIN_W:0]       prod_a, prod_b;

  // A word flagged as block start sees cleared state until its first frame.
  assign start      = head_item_i.first && !busy_q;
  assign eff_phase  = start ? '0 : phase_q;
  assign eff_skip   = start ? '0 : skip_q;
  assign eff_cnt    = start ? '0 : cnt_q;
  assign eff_fidx   = start ? '0 : fidx_q;
  assign eff_facc   = start ? '0 : facc_q;
  assign eff_gain   = start ? '0 : gain_q;
  assign eff_fading = start ? head_item_i.fade : fading_q;
  assign eff_limit  = start ? 1'b0 : limit_q;

  assign drop      = head_i.valid && (eff_limit || (eff_skip != '0));
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign emit      = head_i.valid && !drop && slot_free;

  assign fade_now  = eff_fading && (eff_fidx < cfg_i.fade_frames);
  assign facc_sum  = ACC_W'(eff_facc) + ACC_W'(cfg_i.ramp_inc);
  assign gain_sum  = (GAIN_W + 1)'(eff_gain) + (GAIN_W + 1)'(facc_sum[ACC_W-1:PHASE_W]);
  assign gain_new  = (gain_sum > (GAIN_W + 1)'(GAIN_FULL)) ? GAIN_W'(GAIN_FULL)
                                                           : gain_sum[GAIN_W-1:0];
  assign gain_s    = signed'({1'b0, gain_new});
  assign prod_a    = head_item_i.quo_a * gain_s;
  assign prod_b    = head_item_i.quo_b * gain_s;
  assign fidx_next = (FRAMES_W + 1)'(eff_fidx) + 1'b1;

  assign step_eff  = (cfg_i.step < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : cfg_i.step;
  assign acc_sum   = ACC_W'(eff_phase) + ACC_W'(step_eff);
  assign adv       = acc_sum[ACC_W-1:PHASE_W];
  assign cnt_new   = eff_cnt + 1'b1;
  assign hit       = cnt_new >= CNT_W'(MAX_OUT_FRAMES);
  assign run_done  = (adv != '0) || hit;

  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    cnt_d    = cnt_q;
    fidx_d   = fidx_q;
    facc_d   = facc_q;
    gain_d   = gain_q;
    fading_d = fading_q;
    limit_d  = limit_q;
    busy_d   = busy_q;
    pop_o    = 1'b0;
    out_a_d  = head_item_i.ch_a;
    out_b_d  = head_item_i.ch_b;
    if (drop) begin
      phase_d  = eff_phase;
      cnt_d    = eff_cnt;
      fidx_d   = eff_fidx;
      facc_d   = eff_facc;
      gain_d   = eff_gain;
      fading_d = eff_fading;
      limit_d  = eff_limit;
      skip_d   = eff_limit ? eff_skip : eff_skip - 1'b1;
      busy_d   = 1'b0;
      pop_o    = 1'b1;
    end else if (emit) begin
      phase_d = acc_sum[PHASE_W-1:0];
      cnt_d   = cnt_new;
      limit_d = hit;
      skip_d  = (adv != '0) ? SKIP_W'(adv - 1'b1) : '0;
      if (fade_now) begin
        facc_d   = facc_sum[PHASE_W-1:0];
        gain_d   = gain_new;
        fidx_d   = fidx_next[FRAMES_W-1:0];
        fading_d = fidx_next < (FRAMES_W + 1)'(cfg_i.fade_frames);
        out_a_d  = prod_a[SAMPLE_W-1:0];
        out_b_d  = prod_b[SAMPLE_W-1:0];
      end else begin
        facc_d   = eff_facc;
        gain_d   = eff_gain;
        fidx_d   = eff_fidx;
        fading_d = 1'b0;
      end
      busy_d = !run_done;
      pop_o  = run_done;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      skip_q      <= '0;
      cnt_q       <= '0;
      fidx_q      <= '0;
      facc_q      <= '0;
      gain_q      <= '0;
      fading_q    <= 1'b0;
      limit_q     <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      cnt_q       <= cnt_d;
      fidx_q      <= fidx_d;
      facc_q      <= facc_d;
      gain_q      <= gain_d;
      fading_q    <= fading_d;
      limit_q     <= limit_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_a_q         <= out_a_d;
      out_b_q         <= out_b_d;
      out_run_end_q   <= run_done;
      out_block_end_q <= hit || ((adv != '0) && head_item_i.last);
      out_trunc_q     <= hit;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_b_q, out_a_q};
  assign m_axis_tuser_o  = {out_trunc_q, out_run_end_q};
  assign m_axis_tlast_o  = out_block_end_q;

  `HRFI_ASSERT_IMPL(a_gain_capped, 1'b1, gain_q <= GAIN_W'(GAIN_FULL))
  `HRFI_ASSERT_IMPL(a_limit_count, limit_q, cnt_q == CNT_W'(MAX_OUT_FRAMES))
  `HRFI_ASSERT_IMPL(a_busy_head, busy_q, head_i.valid)
  `HRFI_ASSERT_IMPL(a_trunc_ends, out_valid_q && out_trunc_q, out_block_end_q && out_run_end_q)
  `HRFI_ASSERT_NEXT(a_run_holds, emit && !run_done, busy_q && !out_run_end_q)

endmodule

`default_nettype wire
